// ===== sv/spis_pkg.sv =====
// shared definitions for the scripted pad input sequencer
// store geometry, entry layout, op codes and the store access bundle
// no dependencies
package spis_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam logic [2:0] OP_WAIT    = 3'd0;
	localparam logic [2:0] OP_PRESS   = 3'd1;
	localparam logic [2:0] OP_HOLD    = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_STICK   = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic MODE_SCRIPT = 1'b0;
	localparam logic MODE_MOVIE  = 1'b1;

	typedef struct packed {
		logic [2:0]         op;
		logic [15:0]        buttons;
		logic signed [7:0]  sx;
		logic signed [7:0]  sy;
		logic signed [16:0] count;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== sv/spis_store.sv =====
// entry store of the sequencer: one write port, one registered read port
// depends on spis_pkg for depth and entry layout
module spis_store (
	input  logic              clk,
	input  spis_pkg::mem_req_t req,
	output spis_pkg::entry_t  rd_entry
);
	import spis_pkg::*;

	entry_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_entry <= mem[req.raddr];
		end
	end

endmodule

// ===== sv/spis_seq.sv =====
// playback sequencer: appends entries, walks the script one entry at a time,
// merges script or movie state into the live pad; depends on spis_pkg
module spis_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     play_mode,
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  logic [2:0]               entry_op,
	input  logic [15:0]              entry_buttons,
	input  logic signed [7:0]        entry_stick_x,
	input  logic signed [7:0]        entry_stick_y,
	input  logic signed [16:0]       entry_count,
	input  logic [15:0]              pad_buttons,
	input  logic signed [7:0]        pad_stick_x,
	input  logic signed [7:0]        pad_stick_y,
	output logic                     out_valid,
	output logic [15:0]              out_buttons,
	output logic signed [7:0]        out_stick_x,
	output logic signed [7:0]        out_stick_y,
	output logic                     finished,
	output logic                     load_rejected,
	output spis_pkg::mem_req_t       mem_req,
	input  spis_pkg::entry_t         rd_entry
);
	import spis_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_MOVIE = 4'b1000
	} seq_state_t;

	function automatic logic [15:0] nonneg(input logic signed [16:0] c);
		return c[16] ? 16'd0 : c[15:0];
	endfunction

	seq_state_t         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pos_q;
	logic [15:0]        rr_q;
	logic [15:0]        pressed_q;
	logic [15:0]        held_q;
	logic [15:0]        stick_q;
	logic signed [16:0] timer_q;
	logic               done_q;

	logic [15:0]        pad_btn_q;
	logic signed [7:0]  pad_sx_q;
	logic signed [7:0]  pad_sy_q;

	logic               out_valid_q;
	logic [15:0]        out_btn_q;
	logic signed [7:0]  out_sx_q;
	logic signed [7:0]  out_sy_q;
	logic               fin_q;
	logic               rej_q;

	logic               accept;
	logic               full;
	logic               pos_lt;
	logic               scan_more;
	logic               stick_on;
	logic               timer_pos;

	logic               emit;
	logic [15:0]        res_btn;
	logic signed [7:0]  res_sx;
	logic signed [7:0]  res_sy;
	logic               res_fin;
	logic               res_rej;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (cnt_q == CNT_W'(STORE_DEPTH));
	assign pos_lt    = (pos_q < cnt_q);
	assign scan_more = (rr_q == 16'd0) && pos_lt;
	assign stick_on  = (timer_q != 17'sd0);
	assign timer_pos = !timer_q[16] && stick_on;
	assign busy      = (state_q != ST_IDLE);

	assign mem_req.we    = accept && (command == CMD_LOAD) && !full;
	assign mem_req.waddr = cnt_q[ADDR_W-1:0];
	assign mem_req.wdata = '{op: entry_op, buttons: entry_buttons, sx: entry_stick_x,
		sy: entry_stick_y, count: entry_count};
	assign mem_req.re    = (accept && (command == CMD_READ) && (play_mode == MODE_MOVIE))
		|| ((state_q == ST_SCAN) && scan_more);
	assign mem_req.raddr = pos_q[ADDR_W-1:0];

	// result of the transaction that finishes in this cycle, if any
	always_comb begin
		emit    = 1'b0;
		res_btn = pad_buttons;
		res_sx  = pad_stick_x;
		res_sy  = pad_stick_y;
		res_fin = done_q;
		res_rej = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_LOAD) begin
						emit    = 1'b1;
						res_btn = 16'd0;
						res_sx  = 8'sd0;
						res_sy  = 8'sd0;
						res_fin = 1'b0;
						res_rej = full;
					end else if (cnt_q == '0) begin
						emit = 1'b1;
					end else if (play_mode == MODE_MOVIE) begin
						if (!pos_lt) begin
							emit    = 1'b1;
							res_fin = 1'b1;
						end
					end else if (done_q) begin
						emit = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				emit    = !scan_more;
				res_btn = pad_btn_q | held_q | ((rr_q != 16'd0) ? pressed_q : 16'd0);
				res_sx  = stick_on ? stick_q[7:0] : pad_sx_q;
				res_sy  = stick_on ? stick_q[15:8] : pad_sy_q;
				res_fin = done_q || (rr_q == 16'd0);
			end
			ST_MOVIE: begin
				emit    = 1'b1;
				res_btn = pad_btn_q | rd_entry.buttons;
				if (rd_entry.sx != 8'sd0 || rd_entry.sy != 8'sd0) begin
					res_sx = rd_entry.sx;
					res_sy = rd_entry.sy;
				end else begin
					res_sx = pad_sx_q;
					res_sy = pad_sy_q;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			pos_q     <= '0;
			rr_q      <= '0;
			pressed_q <= '0;
			held_q    <= '0;
			stick_q   <= '0;
			timer_q   <= -17'sd1;
			done_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (command == CMD_LOAD) begin
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							done_q <= 1'b0;
						end else if (cnt_q != '0) begin
							if (play_mode == MODE_MOVIE) begin
								if (pos_lt) begin
									state_q <= ST_MOVIE;
								end else begin
									done_q <= 1'b1;
								end
							end else if (!done_q) begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						state_q <= ST_EXEC;
					end else begin
						if (rr_q != 16'd0) begin
							rr_q <= rr_q - 16'd1;
							if (rr_q == 16'd1) begin
								pressed_q <= '0;
							end
						end else begin
							// nothing left to wait on and the store is used up
							done_q <= 1'b1;
						end
						if (timer_pos) begin
							timer_q <= timer_q - 17'sd1;
							if (timer_q == 17'sd1) begin
								stick_q <= '0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EXEC: begin
					case (rd_entry.op)
						OP_WAIT: begin
							rr_q <= nonneg(rd_entry.count);
						end
						OP_PRESS: begin
							pressed_q <= rd_entry.buttons;
							rr_q      <= nonneg(rd_entry.count);
						end
						OP_HOLD: begin
							held_q <= held_q | rd_entry.buttons;
						end
						OP_RELEASE: begin
							held_q <= held_q & ~rd_entry.buttons;
						end
						OP_STICK: begin
							stick_q <= {rd_entry.sy, rd_entry.sx};
							timer_q <= rd_entry.count;
						end
						default: begin
							rr_q <= rr_q;
						end
					endcase
					pos_q   <= pos_q + CNT_W'(1);
					state_q <= ST_SCAN;
				end
				ST_MOVIE: begin
					pos_q   <= pos_q + CNT_W'(1);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// live pad captured with the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			pad_btn_q <= pad_buttons;
			pad_sx_q  <= pad_stick_x;
			pad_sy_q  <= pad_stick_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_btn_q <= res_btn;
			out_sx_q  <= res_sx;
			out_sy_q  <= res_sy;
			fin_q     <= res_fin;
			rej_q     <= res_rej;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_buttons   = out_btn_q;
	assign out_stick_x   = out_sx_q;
	assign out_stick_y   = out_sy_q;
	assign finished      = fin_q;
	assign load_rejected = rej_q;

endmodule

// ===== sv/scripted_pad_input_sequencer.sv =====
// scripted pad input sequencer, top level
// holds the play mode register and joins the sequencer to the entry store
// depends on spis_pkg, spis_store and spis_seq
//
// usage:
//   a transaction is taken at a clock edge with start high and busy low.
//   command 0 appends one entry to the store (dropped and flagged by
//   load_rejected when the store is full); command 1 is one controller read
//   carrying the live pad and returns the merged pad.
//   every transaction gives exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot hold it off.
//   a load shows its result in the cycle after it is taken and busy stays
//   low, so loads go one per cycle. a movie read answers from the movie
//   state with the entry read from the store. a script read runs entries
//   until a wait or press sets a nonzero count or none are left; each costs a
//   store read and an execute step on the single read port. reads with no
//   store access (empty store, finished script or movie) answer next cycle.
//   play_mode is to be written through cfg_valid/cfg_ready/cfg_data while
//   idle, which the block does not enforce; cfg_ready is always high.
//   reset clears the counters, masks, flags and play mode and sets the
//   stick timer to indefinite; store contents are not cleared, only the
//   written entries are ever used.
module scripted_pad_input_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [2:0]         entry_op,
	input  logic [15:0]        entry_buttons,
	input  logic signed [7:0]  entry_stick_x,
	input  logic signed [7:0]  entry_stick_y,
	input  logic signed [16:0] entry_count,
	input  logic [15:0]        pad_buttons,
	input  logic signed [7:0]  pad_stick_x,
	input  logic signed [7:0]  pad_stick_y,
	output logic               out_valid,
	output logic [15:0]        out_buttons,
	output logic signed [7:0]  out_stick_x,
	output logic signed [7:0]  out_stick_y,
	output logic               finished,
	output logic               load_rejected
);
	import spis_pkg::*;

	logic     play_mode_q;
	mem_req_t mem_req;
	entry_t   rd_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q <= MODE_SCRIPT;
		end else if (cfg_valid && cfg_ready) begin
			play_mode_q <= cfg_data;
		end
	end

	spis_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.rd_entry (rd_entry)
	);

	spis_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.play_mode     (play_mode_q),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.entry_op      (entry_op),
		.entry_buttons (entry_buttons),
		.entry_stick_x (entry_stick_x),
		.entry_stick_y (entry_stick_y),
		.entry_count   (entry_count),
		.pad_buttons   (pad_buttons),
		.pad_stick_x   (pad_stick_x),
		.pad_stick_y   (pad_stick_y),
		.out_valid     (out_valid),
		.out_buttons   (out_buttons),
		.out_stick_x   (out_stick_x),
		.out_stick_y   (out_stick_y),
		.finished      (finished),
		.load_rejected (load_rejected),
		.mem_req       (mem_req),
		.rd_entry      (rd_entry)
	);

endmodule

// ===== sv/spis_checker.sv =====
// port level checks for the scripted pad input sequencer
// bound to the top level; depends on its ports and spis_pkg
module spis_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               command,
	input logic               out_valid,
	input logic [15:0]        out_buttons,
	input logic signed [7:0]  out_stick_x,
	input logic signed [7:0]  out_stick_y,
	input logic               finished,
	input logic               load_rejected
);
	import spis_pkg::*;

	// a load answers in the next cycle with a cleared pad and finished low
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_LOAD |=> out_valid && !finished
			&& out_buttons == 16'd0 && out_stick_x == 8'sd0 && out_stick_y == 8'sd0)
		else $error("load transaction without its result");

	// loads never occupy the sequencer
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_LOAD |=> !busy)
		else $error("busy raised by a load");

	// a result only follows a taken transaction or sequencer work
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy) || $past(start))
		else $error("result strobe with no transaction behind it");

	// a read answer never claims a rejected load
	a_read_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_READ |=> !(out_valid && load_rejected))
		else $error("read result flagged as rejected");

endmodule

bind scripted_pad_input_sequencer spis_checker u_spis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.command       (command),
	.out_valid     (out_valid),
	.out_buttons   (out_buttons),
	.out_stick_x   (out_stick_x),
	.out_stick_y   (out_stick_y),
	.finished      (finished),
	.load_rejected (load_rejected)
);
